// ===== rtl/core/afrt_pkg.sv =====
// ----------------------------------------------------------------------------
// afrt_pkg
// shared types and constants of the aging frequency ranked table
// ----------------------------------------------------------------------------
package afrt_pkg;

    localparam int KEY_BITS   = 32;
    localparam int RANK_BITS  = 16;
    localparam int CFG_BITS   = 6;
    localparam int POS_BITS   = 5;

    localparam logic [RANK_BITS-1:0] START_RANK = 16'd20;
    localparam logic [RANK_BITS-1:0] HIT_GAIN   = 16'd2;
    localparam logic [RANK_BITS-1:0] AGE_STEP   = 16'd1;
    localparam logic [RANK_BITS-1:0] RANK_MAX   = 16'hFFFF;
    localparam logic [CFG_BITS-1:0]  LIMIT_RST  = 6'd30;

    localparam logic OP_HIT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic                op;
        logic [KEY_BITS-1:0] key;
        logic [5:0]          max_count;
    } in_item_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  entry_key;
        logic [RANK_BITS-1:0] entry_rank;
        logic [POS_BITS-1:0]  position;
        logic                 empty_res;
        logic                 last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_WR,
        ST_MV_SETUP,
        ST_MV_CHK,
        ST_MV_CMP,
        ST_TRIM,
        ST_RD_SETUP,
        ST_RD_EMPTY,
        ST_RD_ADDR,
        ST_RD_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_wr;
        logic mv_setup;
        logic mv_rd;
        logic mv_shift;
        logic mv_place;
        logic trim;
        logic rd_setup;
        logic rd_addr;
        logic rd_out;
        logic rd_empty;
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic count_zero;
        logic scan_last;
        logic cur_zero;
        logic shift_ok;
        logic rd_none;
        logic rd_last;
    } dp_status_t;

endpackage

// ===== rtl/core/afrt_ram.sv =====
// ----------------------------------------------------------------------------
// afrt_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module afrt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/afrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// afrt_ctrl
// sequencer for hit and read items
// ----------------------------------------------------------------------------
module afrt_ctrl
    import afrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (start) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                priority if (status.is_read) state_next = ST_RD_SETUP;
                else if (status.count_zero)  state_next = ST_MV_SETUP;
                else                         state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:  state_next = ST_SCAN_WR;
            ST_SCAN_WR:  state_next = status.scan_last ? ST_MV_SETUP : ST_SCAN_RD;
            ST_MV_SETUP: state_next = ST_MV_CHK;
            ST_MV_CHK:   state_next = status.cur_zero ? ST_TRIM : ST_MV_CMP;
            ST_MV_CMP:   state_next = status.shift_ok ? ST_MV_CHK : ST_TRIM;
            ST_TRIM:     state_next = ST_IDLE;
            ST_RD_SETUP: state_next = status.rd_none ? ST_RD_EMPTY : ST_RD_ADDR;
            ST_RD_EMPTY: state_next = ST_IDLE;
            ST_RD_ADDR:  state_next = ST_RD_OUT;
            ST_RD_OUT:   state_next = status.rd_last ? ST_IDLE : ST_RD_ADDR;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DISPATCH: ;
            ST_SCAN_RD:  cmd.scan_rd  = 1'b1;
            ST_SCAN_WR:  cmd.scan_wr  = 1'b1;
            ST_MV_SETUP: cmd.mv_setup = 1'b1;
            ST_MV_CHK:
            begin
                cmd.mv_place = status.cur_zero;
                cmd.mv_rd    = !status.cur_zero;
            end
            ST_MV_CMP:
            begin
                cmd.mv_shift = status.shift_ok;
                cmd.mv_place = !status.shift_ok;
            end
            ST_TRIM:     cmd.trim     = 1'b1;
            ST_RD_SETUP: cmd.rd_setup = 1'b1;
            ST_RD_EMPTY: cmd.rd_empty = 1'b1;
            ST_RD_ADDR:  cmd.rd_addr  = 1'b1;
            ST_RD_OUT:   cmd.rd_out   = 1'b1;
            default:     busy = 1'b1;
        endcase
    end

endmodule

// ===== rtl/core/afrt_dp.sv =====
// ----------------------------------------------------------------------------
// afrt_dp
// entry store, counters, compare and result register
// ----------------------------------------------------------------------------
module afrt_dp
    import afrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  in_item_t            item,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output out_item_t           result,
    output logic                result_valid
);

    localparam int DEPTH = MAX_ENTRIES + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_ENTRIES + 2);
    localparam int LW    = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int WW    = KEY_BITS + RANK_BITS;

    logic [CFG_BITS-1:0]  limit_cfg_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        cur_reg;
    logic [LW-1:0]        n_reg;
    in_item_t             item_reg;
    logic                 found_reg;
    logic [RANK_BITS-1:0] hit_rank_reg;
    logic [RANK_BITS-1:0] mv_rank_reg;
    logic [KEY_BITS-1:0]  mv_key_reg;
    out_item_t            result_reg;
    logic                 result_valid_reg;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [WW-1:0]        wdata;
    logic [AW-1:0]        raddr;
    logic [WW-1:0]        rdata;
    logic [KEY_BITS-1:0]  rd_key;
    logic [RANK_BITS-1:0] rd_rank;
    logic [RANK_BITS-1:0] aged;
    logic [RANK_BITS:0]   gained;
    logic [LW-1:0]        cfg_ext;
    logic [LW-1:0]        limit;
    logic [LW-1:0]        count_ext;
    logic [LW-1:0]        idx_ext;
    logic [LW-1:0]        maxc_ext;
    logic [LW-1:0]        n_calc;
    logic [CW-1:0]        cur_dec;

    afrt_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_key  = rdata[WW-1:RANK_BITS];
    assign rd_rank = rdata[RANK_BITS-1:0];
    assign aged    = (rd_rank >= AGE_STEP) ? rd_rank - AGE_STEP : '0;
    assign gained  = {1'b0, hit_rank_reg} + {1'b0, HIT_GAIN};
    assign cur_dec = cur_reg - CW'(1);

    // limit clamped to 1..MAX_ENTRIES
    assign cfg_ext   = LW'(limit_cfg_reg);
    assign limit     = (cfg_ext == '0) ? LW'(1)
                     : (cfg_ext > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : cfg_ext;
    assign count_ext = LW'(count_reg);
    assign idx_ext   = LW'(idx_reg);
    assign maxc_ext  = LW'(item_reg.max_count);

    always_comb
    begin
        n_calc = maxc_ext;
        if (n_calc > limit)     n_calc = limit;
        if (n_calc > count_ext) n_calc = count_ext;
    end

    always_comb
    begin
        raddr = '0;
        if (cmd.scan_rd || cmd.rd_addr)
        begin
            raddr = idx_reg[AW-1:0];
        end
        else if (cmd.mv_rd)
        begin
            raddr = cur_dec[AW-1:0];
        end
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = {rd_key, aged};
        if (cmd.scan_wr)
        begin
            we = 1'b1;
        end
        else if (cmd.mv_shift)
        begin
            we    = 1'b1;
            waddr = cur_reg[AW-1:0];
            wdata = rdata;
        end
        else if (cmd.mv_place)
        begin
            we    = 1'b1;
            waddr = cur_reg[AW-1:0];
            wdata = {mv_key_reg, mv_rank_reg};
        end
    end

    assign status.is_read    = (item_reg.op == OP_READ);
    assign status.count_zero = (count_reg == '0);
    assign status.scan_last  = (idx_reg + CW'(1) == count_reg);
    assign status.cur_zero   = (cur_reg == '0);
    assign status.shift_ok   = (rd_rank < mv_rank_reg);
    assign status.rd_none    = (n_calc == '0);
    assign status.rd_last    = (idx_ext + LW'(1) == n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_cfg_reg    <= LIMIT_RST;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_cfg_reg <= cfg_data;
            end
            if (cmd.mv_setup && !found_reg)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.trim && (count_ext > limit))
            begin
                count_reg <= count_reg - CW'(1);
            end
            result_valid_reg <= cmd.rd_out || cmd.rd_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg  <= item;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.scan_wr)
        begin
            idx_reg <= idx_reg + CW'(1);
            if (!found_reg && (rd_key == item_reg.key))
            begin
                found_reg    <= 1'b1;
                hit_rank_reg <= aged;
                cur_reg      <= idx_reg;
            end
        end
        if (cmd.mv_setup)
        begin
            mv_key_reg <= item_reg.key;
            if (found_reg)
            begin
                mv_rank_reg <= gained[RANK_BITS] ? RANK_MAX : gained[RANK_BITS-1:0];
            end
            else
            begin
                mv_rank_reg <= START_RANK;
                cur_reg     <= count_reg;
            end
        end
        if (cmd.mv_shift)
        begin
            cur_reg <= cur_dec;
        end
        if (cmd.rd_setup)
        begin
            n_reg   <= n_calc;
            idx_reg <= '0;
        end
        if (cmd.rd_out)
        begin
            idx_reg              <= idx_reg + CW'(1);
            result_reg.entry_key  <= rd_key;
            result_reg.entry_rank <= rd_rank;
            result_reg.position   <= idx_ext[POS_BITS-1:0];
            result_reg.empty_res  <= 1'b0;
            result_reg.last       <= (idx_ext + LW'(1) == n_reg);
        end
        else if (cmd.rd_empty)
        begin
            result_reg <= '{entry_key: '0, entry_rank: '0, position: '0,
                            empty_res: 1'b1, last: 1'b1};
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/core/aging_frequency_ranked_table.sv =====
// ----------------------------------------------------------------------------
// aging_frequency_ranked_table
// ranked key list with aging, hit recording and ordered readout
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A hit item ages every
// stored rank by one, adds the key (rank 20) or raises its rank by 2, bubbles
// it toward the head past lower ranks and evicts the tail above the limit; it
// produces no result. A hit runs the aging scan over all stored entries,
// moves the entry one position per compare and then places it and trims. A
// read returns the first min(max_count, limit, count) entries in order, or
// one empty result. The single entry ram has one read and one write port.
// Results appear one cycle each, marked by result_valid; the receiver cannot
// stall them, so it must take every strobed item. cfg_ready is high only
// while the block is idle.
// ----------------------------------------------------------------------------
module aging_frequency_ranked_table
    import afrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                start,
    output logic                busy,
    input  in_item_t            cmd,
    // results, one strobe per read entry or empty read; hits give none
    output logic                result_valid,
    output out_item_t           result,
    // limit register write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // register writes only when no item is in flight
    assign cfg_ready = !busy;

    afrt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (dp_status),
        .cmd    (dp_cmd)
    );

    afrt_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (cmd),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
